FILE: rtl/elpv_pkg.sv
package elpv_pkg;

  localparam int unsigned CountWidth = 9;
  localparam logic [CountWidth-1:0] CountLimit = 9'd511;
  localparam logic [7:0] MaxLengthReset = 8'd64;

  localparam logic [7:0] QuoteChar = 8'd34;
  localparam logic [7:0] BackslashChar = 8'd92;
  localparam logic [7:0] DotChar = 8'd46;
  localparam logic [7:0] TabChar = 8'd9;
  localparam logic [7:0] PrintLow = 8'd32;
  localparam logic [7:0] PrintHigh = 8'd126;

  localparam logic [3:0] ERR_OK = 4'd0;
  localparam logic [3:0] ERR_EMPTY = 4'd1;
  localparam logic [3:0] ERR_TOO_LONG = 4'd2;
  localparam logic [3:0] ERR_QUOTED_EMPTY = 4'd3;
  localparam logic [3:0] ERR_BAD_ESCAPE = 4'd4;
  localparam logic [3:0] ERR_BAD_QUOTED = 4'd5;
  localparam logic [3:0] ERR_EDGE_DOT = 4'd6;
  localparam logic [3:0] ERR_DOUBLE_DOT = 4'd7;
  localparam logic [3:0] ERR_BAD_PLAIN = 4'd8;

  localparam logic [1:0] QERR_NONE = 2'd0;
  localparam logic [1:0] QERR_ESCAPE = 2'd1;
  localparam logic [1:0] QERR_QUOTED = 2'd2;

  localparam logic [1:0] PERR_NONE = 2'd0;
  localparam logic [1:0] PERR_DOUBLE_DOT = 2'd1;
  localparam logic [1:0] PERR_BAD_CHAR = 2'd2;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       has_byte;
    logic       end_of_string;
  } elpv_item_t;

  typedef struct packed {
    logic       is_valid;
    logic [3:0] error_code;
    logic       was_quoted;
  } elpv_result_t;

  function automatic logic plain_ok(input logic [7:0] c);
    logic ok;
    ok = 1'b0;
    if (c inside {[8'd65:8'd90], [8'd97:8'd122], [8'd48:8'd57]}) begin
      ok = 1'b1;
    end else if (c inside {8'd33, 8'd35, 8'd36, 8'd37, 8'd38, 8'd39, 8'd42, 8'd43,
                           8'd45, 8'd47, 8'd61, 8'd63, 8'd94, 8'd95, 8'd96, 8'd123,
                           8'd124, 8'd125, 8'd126, 8'd46}) begin
      ok = 1'b1;
    end
    return ok;
  endfunction

  function automatic logic printable(input logic [7:0] c);
    return (c >= PrintLow) && (c <= PrintHigh);
  endfunction

endpackage

FILE: rtl/elpv_ifs.sv
interface elpv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       has_byte;
  logic       end_of_string;

  modport source (output valid, output byte_value, output has_byte,
                  output end_of_string, input ready);
  modport sink (input valid, input byte_value, input has_byte,
                input end_of_string, output ready);
endinterface

interface elpv_out_if;
  logic       valid;
  logic       ready;
  logic       is_valid;
  logic [3:0] error_code;
  logic       was_quoted;

  modport source (output valid, output is_valid, output error_code,
                  output was_quoted, input ready);
  modport sink (input valid, input is_valid, input error_code,
                input was_quoted, output ready);
endinterface

interface elpv_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] max_length;

  modport source (output valid, output max_length, input ready);
  modport sink (input valid, input max_length, output ready);
endinterface

FILE: rtl/elpv_in_stage.sv
module elpv_in_stage
  import elpv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  elpv_in_if.sink     chars,
  input  logic        take,
  output logic        valid,
  output elpv_item_t  item
);

  assign chars.ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (chars.ready) begin
      valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      item.byte_value <= chars.byte_value;
      item.has_byte <= chars.has_byte;
      item.end_of_string <= chars.end_of_string;
    end
  end

endmodule

FILE: rtl/elpv_check.sv
module elpv_check
  import elpv_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         fire,
  input  elpv_item_t   item,
  input  logic [7:0]   max_length,
  output elpv_result_t result
);

  logic [CountWidth-1:0] byte_count, byte_count_next;
  logic [7:0] first_byte, first_byte_next;
  logic [7:0] pending_byte, pending_byte_next;
  logic escape_pending, escape_pending_next;
  logic dot_before, dot_before_next;
  logic [1:0] quoted_first_error, quoted_first_error_next;
  logic [1:0] plain_first_error, plain_first_error_next;
  logic [7:0] c;
  logic [3:0] code;
  logic quoted;

  assign c = item.byte_value;

  always_comb begin
    byte_count_next = byte_count;
    first_byte_next = first_byte;
    pending_byte_next = pending_byte;
    escape_pending_next = escape_pending;
    dot_before_next = dot_before;
    quoted_first_error_next = quoted_first_error;
    plain_first_error_next = plain_first_error;
    if (item.has_byte) begin
      if (byte_count >= CountWidth'(2)) begin
        if (escape_pending) begin
          escape_pending_next = 1'b0;
          if (pending_byte != TabChar && !printable(pending_byte)
              && quoted_first_error == QERR_NONE) begin
            quoted_first_error_next = QERR_ESCAPE;
          end
        end else if (pending_byte == BackslashChar) begin
          escape_pending_next = 1'b1;
        end else if ((!printable(pending_byte) || pending_byte == QuoteChar)
                     && quoted_first_error == QERR_NONE) begin
          quoted_first_error_next = QERR_QUOTED;
        end
      end
      if (byte_count == '0) begin
        first_byte_next = c;
      end
      if (c == DotChar) begin
        if (dot_before && plain_first_error == PERR_NONE) begin
          plain_first_error_next = PERR_DOUBLE_DOT;
        end
        dot_before_next = 1'b1;
      end else begin
        dot_before_next = 1'b0;
        if (!plain_ok(c) && plain_first_error == PERR_NONE) begin
          plain_first_error_next = PERR_BAD_CHAR;
        end
      end
      pending_byte_next = c;
      if (byte_count < CountLimit) begin
        byte_count_next = byte_count + CountWidth'(1);
      end
    end
  end

  always_comb begin
    code = ERR_OK;
    quoted = 1'b0;
    if (byte_count_next == '0) begin
      code = ERR_EMPTY;
    end else if (byte_count_next > {1'b0, max_length}) begin
      code = ERR_TOO_LONG;
    end else if (first_byte_next == QuoteChar && pending_byte_next == QuoteChar) begin
      quoted = 1'b1;
      if (byte_count_next <= CountWidth'(2)) begin
        code = ERR_QUOTED_EMPTY;
      end else if (quoted_first_error_next == QERR_ESCAPE) begin
        code = ERR_BAD_ESCAPE;
      end else if (quoted_first_error_next == QERR_QUOTED) begin
        code = ERR_BAD_QUOTED;
      end
    end else begin
      if (first_byte_next == DotChar || pending_byte_next == DotChar) begin
        code = ERR_EDGE_DOT;
      end else if (plain_first_error_next == PERR_DOUBLE_DOT) begin
        code = ERR_DOUBLE_DOT;
      end else if (plain_first_error_next == PERR_BAD_CHAR) begin
        code = ERR_BAD_PLAIN;
      end
    end
    result.is_valid = (code == ERR_OK);
    result.error_code = code;
    result.was_quoted = quoted;
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && item.end_of_string)) begin
      byte_count <= '0;
      first_byte <= '0;
      pending_byte <= '0;
      escape_pending <= 1'b0;
      dot_before <= 1'b0;
      quoted_first_error <= QERR_NONE;
      plain_first_error <= PERR_NONE;
    end else if (fire) begin
      byte_count <= byte_count_next;
      first_byte <= first_byte_next;
      pending_byte <= pending_byte_next;
      escape_pending <= escape_pending_next;
      dot_before <= dot_before_next;
      quoted_first_error <= quoted_first_error_next;
      plain_first_error <= plain_first_error_next;
    end
  end

endmodule

FILE: rtl/elpv_out_stage.sv
module elpv_out_stage
  import elpv_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  elpv_result_t  result,
  output logic          room,
  elpv_out_if.source    verdict
);

  assign room = !verdict.valid || verdict.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict.valid <= 1'b0;
    end else if (load) begin
      verdict.valid <= 1'b1;
    end else if (verdict.ready) begin
      verdict.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      verdict.is_valid <= result.is_valid;
      verdict.error_code <= result.error_code;
      verdict.was_quoted <= result.was_quoted;
    end
  end

endmodule

FILE: rtl/email_local_part_validator.sv
// The verdict is registered as the string-ending beat leaves the input register.
// Throughput: one byte beat per cycle; a waiting verdict holds a string-ending beat
// in the input register, and only then is the input stalled until the verdict leaves.
// Reset (rst, synchronous): clears the string state, empties both registers and
// sets max_length to 64.
module email_local_part_validator
  import elpv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  elpv_in_if.sink     chars,
  elpv_cfg_if.sink    cfg,
  elpv_out_if.source  verdict
);

  logic         s1_valid;
  elpv_item_t   s1_item;
  logic         s1_fire;
  logic         room;
  logic         load;
  elpv_result_t result;
  logic [7:0]   max_length;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MaxLengthReset;
    end else if (cfg.valid) begin
      max_length <= cfg.max_length;
    end
  end

  // advance a held beat unless it ends a string and the result slot is full
  assign s1_fire = s1_valid && (!s1_item.end_of_string || room);
  assign load = s1_fire && s1_item.end_of_string;

  elpv_in_stage u_in (
    .clk   (clk),
    .rst   (rst),
    .chars (chars),
    .take  (s1_fire),
    .valid (s1_valid),
    .item  (s1_item)
  );

  elpv_check u_check (
    .clk        (clk),
    .rst        (rst),
    .fire       (s1_fire),
    .item       (s1_item),
    .max_length (max_length),
    .result     (result)
  );

  elpv_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .result  (result),
    .room    (room),
    .verdict (verdict)
  );

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> verdict.valid)
    else $error("verdict not presented after string end");

  a_ok_flag: assert property (@(posedge clk) disable iff (rst)
    verdict.valid |-> (verdict.is_valid == (verdict.error_code == ERR_OK)))
    else $error("is_valid disagrees with error_code");

  a_quoted_codes: assert property (@(posedge clk) disable iff (rst)
    (verdict.valid && verdict.was_quoted) |->
      (verdict.error_code == ERR_OK || verdict.error_code == ERR_QUOTED_EMPTY ||
       verdict.error_code == ERR_BAD_ESCAPE || verdict.error_code == ERR_BAD_QUOTED))
    else $error("quoted verdict with unquoted error");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (verdict.valid && !verdict.ready) |-> !load)
    else $error("pending verdict overwritten");

endmodule
